// File: design/cmsa_pkg.sv
// ----------------------------------------------------------------------------
// Calendar minute step advance package
// Shared types, constants and the month length table.
// ----------------------------------------------------------------------------
package cmsa_pkg;

   localparam int MinuteW = 6;
   localparam int HourW   = 5;
   localparam int DayW    = 5;
   localparam int MonthW  = 4;
   localparam int YearOutW = 14;
   localparam int SkipYearW = 14;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 14;
   localparam int ReqDataW = 8;
   localparam int RspDataW = 40;

   localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
   localparam logic [6:0] LAST_MINUTE      = 7'd59;
   localparam logic [HourW-1:0] LAST_HOUR  = 5'd23;
   localparam logic [MonthW:0] LAST_MONTH  = 5'd12;

   localparam logic [DayW-1:0] DAYS_LONG  = 5'd31;
   localparam logic [DayW-1:0] DAYS_SHORT = 5'd30;
   localparam logic [DayW-1:0] DAYS_LEAP  = 5'd29;
   localparam logic [DayW-1:0] DAYS_FEB   = 5'd28;

   localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
   localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
   localparam logic [MonthW-1:0] MONTH_APR = 4'd4;
   localparam logic [MonthW-1:0] MONTH_JUN = 4'd6;
   localparam logic [MonthW-1:0] MONTH_SEP = 4'd9;
   localparam logic [MonthW-1:0] MONTH_NOV = 4'd11;

   localparam logic [DayW-1:0]    FIRST_DAY = 5'd1;
   localparam logic [MinuteW-1:0] RESET_STEP = 6'd4;
   localparam logic [SkipYearW-1:0] RESET_SKIP_YEAR = 14'd2100;
   localparam int ResetYear = 2000;

   localparam logic [CsrIdxW-1:0] CSR_STEP_MINUTES = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_SKIPPED_LEAP = 1'd1;

   typedef struct packed {
      logic [HourW-1:0]   hour;
      logic [MinuteW-1:0] minute;
   } cmsa_time_type;

   typedef struct packed {
      logic [MonthW-1:0] month;
      logic [DayW-1:0]   day;
   } cmsa_date_type;

   function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                   input logic leap);
      logic [DayW-1:0] days;
      case (month) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = DAYS_SHORT;
         MONTH_FEB: days = leap ? DAYS_LEAP : DAYS_FEB;
         default: days = DAYS_LONG;
      endcase
      return days;
   endfunction

endpackage

// File: design/cmsa_advance.sv
// ----------------------------------------------------------------------------
// Calendar advance logic
// Computes the calendar after one tick: minute, hour, day, month and year carry.
// ----------------------------------------------------------------------------
module cmsa_advance #(
   parameter int YEAR_BITS = 14
) (
   input  logic                            add_step,
   input  logic [cmsa_pkg::MinuteW-1:0]    step_minutes,
   input  logic [cmsa_pkg::SkipYearW-1:0]  skipped_leap_year,
   input  cmsa_pkg::cmsa_time_type         cur_time,
   input  cmsa_pkg::cmsa_date_type         cur_date,
   input  logic [YEAR_BITS-1:0]            cur_year,
   output cmsa_pkg::cmsa_time_type         next_time,
   output cmsa_pkg::cmsa_date_type         next_date,
   output logic [YEAR_BITS-1:0]            next_year
);
   import cmsa_pkg::*;

   localparam int CmpW = (YEAR_BITS > SkipYearW) ? YEAR_BITS : SkipYearW;

   logic [6:0]        minute_sum;
   logic              minute_carry;
   logic [HourW-1:0]  hour_inc;
   logic              hour_carry;
   logic              leap;
   logic [DayW-1:0]   days_in_month;
   logic [DayW:0]     day_inc;
   logic              day_roll;
   logic [MonthW:0]   month_pre;
   logic              month_roll;

   always_comb begin
      minute_sum   = {1'b0, cur_time.minute} + {1'b0, step_minutes};
      minute_carry = add_step && (minute_sum > LAST_MINUTE);
      hour_inc     = cur_time.hour + 5'd1;
      hour_carry   = minute_carry && (hour_inc > LAST_HOUR);

      leap = (cur_year[1:0] == 2'd0) &&
             (CmpW'(cur_year) != CmpW'(skipped_leap_year));
      days_in_month = month_days(cur_date.month, leap);
      day_inc       = {1'b0, cur_date.day} + 6'd1;
      day_roll      = day_inc > {1'b0, days_in_month};
      month_pre     = day_roll ? ({1'b0, cur_date.month} + 5'd1) : {1'b0, cur_date.month};
      month_roll    = month_pre > LAST_MONTH;

      next_time = cur_time;
      next_date = cur_date;
      next_year = cur_year;
      if (add_step) begin
         if (minute_carry) begin
            next_time.minute = MinuteW'(minute_sum - MINUTES_PER_HOUR);
            next_time.hour   = hour_carry ? '0 : hour_inc;
         end else begin
            next_time.minute = minute_sum[MinuteW-1:0];
         end
      end
      if (hour_carry) begin
         next_date.day   = day_roll ? FIRST_DAY : day_inc[DayW-1:0];
         next_date.month = month_roll ? MONTH_JAN : month_pre[MonthW-1:0];
         next_year       = month_roll ? (cur_year + YEAR_BITS'(1)) : cur_year;
      end
   end

endmodule

// File: design/calendar_minute_step_advance_top.sv
// Path: a transferred tick sits in the input register, and its result is then
// presented on rsp_ from the result register once the result register is free.
// Throughput: one tick per cycle; the input register and the result register
// each advance whenever the result register is empty or being drained.
// Reset (synchronous, active high) sets 00:00 on January 1, 2000, step 4 and
// skipped leap year 2100, and empties both register stages.
// ----------------------------------------------------------------------------
// Calendar minute step advance top level
// Calendar counter stepped by a configurable number of minutes per tick.
// ----------------------------------------------------------------------------
module calendar_minute_step_advance_top #(
   parameter int YEAR_BITS = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0: add flag.
   input  logic [cmsa_pkg::ReqDataW-1:0]   req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0: minute, hour, day, month, year.
   output logic [cmsa_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                            csr_we,
   input  logic [cmsa_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [cmsa_pkg::CsrDataW-1:0]   csr_wdata
);
   import cmsa_pkg::*;

   localparam int CmpW = (YEAR_BITS > YearOutW) ? YEAR_BITS : YearOutW;

   logic [MinuteW-1:0]   step_ff;
   logic [SkipYearW-1:0] skip_year_ff;
   logic                 s1_valid_ff;
   logic                 s1_add_ff;
   cmsa_time_type        time_ff;
   cmsa_date_type        date_ff;
   logic [YEAR_BITS-1:0] year_ff;
   logic                 rsp_valid_ff;
   logic [RspDataW-1:0]  rsp_data_ff;

   cmsa_time_type        time_in;
   cmsa_date_type        date_in;
   logic [YEAR_BITS-1:0] year_in;
   logic [RspDataW-1:0]  rsp_data_in;
   logic                 advance;
   logic [CmpW-1:0]      year_ext;

   cmsa_advance #(
      .YEAR_BITS(YEAR_BITS)
   ) u_advance (
      .add_step          (s1_add_ff),
      .step_minutes      (step_ff),
      .skipped_leap_year (skip_year_ff),
      .cur_time          (time_ff),
      .cur_date          (date_ff),
      .cur_year          (year_ff),
      .next_time         (time_in),
      .next_date         (date_in),
      .next_year         (year_in)
   );

   always_comb begin
      advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready  = !s1_valid_ff || advance;
      year_ext    = CmpW'(year_in);
      rsp_data_in = {6'd0, year_ext[YearOutW-1:0], date_in.month, date_in.day,
                     time_in.hour, time_in.minute};
      rsp_tvalid  = rsp_valid_ff;
      rsp_tdata   = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= RESET_STEP;
         skip_year_ff <= RESET_SKIP_YEAR;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEP_MINUTES: step_ff <= csr_wdata[MinuteW-1:0];
            CSR_SKIPPED_LEAP: skip_year_ff <= csr_wdata[SkipYearW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
         date_ff      <= '{month: MONTH_JAN, day: FIRST_DAY};
         year_ff      <= YEAR_BITS'(ResetYear);
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            time_ff <= time_in;
            date_ff <= date_in;
            year_ff <= year_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_add_ff <= req_tdata[0];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The hour never leaves its range.
   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      time_ff.hour <= LAST_HOUR)
      else $error("hour counter out of range");

   // The month stays between January and December.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (date_ff.month >= MONTH_JAN) && ({1'b0, date_ff.month} <= LAST_MONTH))
      else $error("month counter out of range");

   // A tick without the add flag leaves the calendar unchanged.
   a_no_add_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_add_ff) |=> ($stable(time_ff) && $stable(date_ff) && $stable(year_ff)))
      else $error("calendar changed on a tick without add flag");

   // A stalled item in the input register is kept until it moves on.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_add_ff)))
      else $error("stalled tick lost from input register");

endmodule
